/* sv/psched_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_pkg
// Types and constants shared by the prerequisite level scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

    localparam int OP_W    = 2;
    localparam int TASK_W  = 5;
    localparam int ROUND_W = 6;
    localparam int CNT_W   = 6;
    localparam int CFG_W   = 6;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DECL  = 2'd1;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd2;
    localparam logic [OP_W-1:0] OP_PLAN  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] task_id;
        logic [TASK_W-1:0] prereq_id;
    } req_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id_res;
        logic [ROUND_W-1:0] round;
        logic               is_summary;
        logic               last;
    } res_t;

endpackage

/* sv/prerequisite_level_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prerequisite_level_scheduler_core
// Loads a task dependency graph and plans it in width-limited Kahn rounds.
// ----------------------------------------------------------------------------
// Clear and declare requests are handled in idle; an edge request does a RAM read-modify-write.
// Plan: each round runs a snapshot and a closing pick, and a final snapshot ends the plan;
// each scheduled task reads its edge row, then updates the pending-count RAM per dependent.
// First task result is registered from the pick after the snapshot; results are
// one-cycle strobes and the receiver cannot stall. busy is low when idle.
// Reset empties the graph at once (per-entry valid bits) and sets the limit to 4.
// ----------------------------------------------------------------------------
module prerequisite_level_scheduler_core
    import psched_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  req_t             req,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             res_valid,
    output res_t             res
);

    localparam int NT = (MAX_TASKS < 32) ? MAX_TASKS : 32;
    localparam int IW = $clog2(NT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EDGE = 3'd1;
    localparam logic [2:0] S_SNAP = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_ROW  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DWR  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [NT-1:0]      present_reg, present_next;
    logic [NT-1:0]      done_reg, done_next;
    logic [NT-1:0]      zero_reg, zero_next;
    logic [NT-1:0]      edge_vld_reg, edge_vld_next;
    logic [NT-1:0]      pend_vld_reg, pend_vld_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [CFG_W-1:0]   taken_reg, taken_next;
    logic [NT-1:0]      snap_reg, snap_next;
    logic [NT-1:0]      dep_reg, dep_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      p_reg, p_next;
    res_t               res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               e_we;
    logic [IW-1:0]      e_waddr, e_raddr;
    logic [NT-1:0]      e_wdata, e_rdata;
    logic               c_we;
    logic [IW-1:0]      c_waddr, c_raddr;
    logic [CNT_W-1:0]   c_wdata, c_rdata;

    logic [IW-1:0]      pick_idx, dep_idx;
    logic               pick_any, dep_any;

    logic               t_ok, p_ok;
    logic [IW-1:0]      t_idx, p_idx;
    logic [CFG_W-1:0]   lim;
    logic [NT-1:0]      row, ready;
    logic [CNT_W-1:0]   cnt;

    psched_ram #(.WIDTH(NT), .DEPTH(NT)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    psched_ram #(.WIDTH(CNT_W), .DEPTH(NT)) u_cnt_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    psched_ffs #(.N(NT)) u_pick_ffs (
        .vec (snap_reg),
        .idx (pick_idx),
        .any (pick_any)
    );

    psched_ffs #(.N(NT)) u_dep_ffs (
        .vec (dep_reg),
        .idx (dep_idx),
        .any (dep_any)
    );

    assign t_ok  = ({1'b0, req.task_id} < 6'(NT));
    assign p_ok  = ({1'b0, req.prereq_id} < 6'(NT));
    assign t_idx = req.task_id[IW-1:0];
    assign p_idx = req.prereq_id[IW-1:0];
    assign lim   = (cfg_reg == '0) ? CFG_W'(1) : cfg_reg;
    assign ready = present_reg & ~done_reg & zero_reg;
    assign row   = edge_vld_reg[p_reg] ? e_rdata : '0;
    assign cnt   = pend_vld_reg[idx_reg] ? c_rdata : '0;

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        done_next      = done_reg;
        zero_next      = zero_reg;
        edge_vld_next  = edge_vld_reg;
        pend_vld_next  = pend_vld_reg;
        round_next     = round_reg;
        taken_next     = taken_reg;
        snap_next      = snap_reg;
        dep_next       = dep_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        e_we           = 1'b0;
        e_waddr        = p_reg;
        e_wdata        = row;
        e_raddr        = p_idx;
        c_we           = 1'b0;
        c_waddr        = idx_reg;
        c_wdata        = cnt;
        c_raddr        = t_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.op)
                        OP_CLEAR:
                        begin
                            present_next  = '0;
                            done_next     = '0;
                            zero_next     = '1;
                            edge_vld_next = '0;
                            pend_vld_next = '0;
                            round_next    = '0;
                        end
                        OP_DECL:
                        begin
                            if (t_ok)
                            begin
                                present_next[t_idx] = 1'b1;
                            end
                        end
                        OP_EDGE:
                        begin
                            if (t_ok && p_ok)
                            begin
                                idx_next   = t_idx;
                                p_next     = p_idx;
                                state_next = S_EDGE;
                            end
                        end
                        OP_PLAN:
                        begin
                            round_next = '0;
                            state_next = S_SNAP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE:
            begin
                present_next[idx_reg] = 1'b1;
                present_next[p_reg]   = 1'b1;
                if (!row[idx_reg])
                begin
                    e_we                 = 1'b1;
                    e_wdata[idx_reg]     = 1'b1;
                    edge_vld_next[p_reg] = 1'b1;
                    c_we                 = 1'b1;
                    c_wdata              = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
                    pend_vld_next[idx_reg] = 1'b1;
                    zero_next[idx_reg]     = 1'b0;
                end
                state_next = S_IDLE;
            end
            S_SNAP:
            begin
                if (ready == '0)
                begin
                    res_next.task_id_res = '0;
                    res_next.round       = round_reg;
                    res_next.is_summary  = 1'b1;
                    res_next.last        = 1'b1;
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                    snap_next  = ready;
                    taken_next = '0;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!pick_any || taken_reg == lim)
                begin
                    state_next = S_SNAP;
                end
                else
                begin
                    snap_next[pick_idx]  = 1'b0;
                    done_next[pick_idx]  = 1'b1;
                    taken_next           = taken_reg + CFG_W'(1);
                    res_next.task_id_res = TASK_W'(pick_idx);
                    res_next.round       = round_reg;
                    res_next.is_summary  = 1'b0;
                    res_next.last        = 1'b0;
                    res_valid_next       = 1'b1;
                    idx_next             = pick_idx;
                    e_raddr              = pick_idx;
                    state_next           = S_ROW;
                end
            end
            S_ROW:
            begin
                dep_next   = edge_vld_reg[idx_reg] ? e_rdata : '0;
                state_next = S_DRD;
            end
            S_DRD:
            begin
                if (!dep_any)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    dep_next[dep_idx] = 1'b0;
                    c_raddr           = dep_idx;
                    idx_next          = dep_idx;
                    state_next        = S_DWR;
                end
            end
            S_DWR:
            begin
                if (cnt != '0)
                begin
                    c_we               = 1'b1;
                    c_wdata            = cnt - CNT_W'(1);
                    zero_next[idx_reg] = (cnt == CNT_W'(1));
                end
                state_next = S_DRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= CFG_RESET;
            present_reg   <= '0;
            done_reg      <= '0;
            zero_reg      <= '1;
            edge_vld_reg  <= '0;
            pend_vld_reg  <= '0;
            round_reg     <= '0;
            taken_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            done_reg      <= done_next;
            zero_reg      <= zero_next;
            edge_vld_reg  <= edge_vld_next;
            pend_vld_reg  <= pend_vld_next;
            round_reg     <= round_next;
            taken_reg     <= taken_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        dep_reg  <= dep_next;
        idx_reg  <= idx_next;
        p_reg    <= p_next;
        res_reg  <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* sv/psched_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/psched_ffs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_ffs
// Lowest set bit finder over a task bit vector.
// ----------------------------------------------------------------------------
module psched_ffs #(
    parameter int N = 32
) (
    input  logic [N-1:0]         vec,
    output logic [$clog2(N)-1:0] idx,
    output logic                 any
);

    always_comb
    begin
        idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = ($clog2(N))'(i);
            end
        end
        any = |vec;
    end

endmodule

/* sv/psched_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psched_chk
// Port-level checks for the prerequisite level scheduler.
// ----------------------------------------------------------------------------
module psched_chk
    import psched_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input req_t req,
    input logic busy,
    input logic res_valid,
    input res_t res
);

    // every result comes out of planning work
    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy))
        else $error("result without preceding busy cycle");

    // a task result leaves the plan still running
    a_task_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_summary |-> busy && res.round != '0)
        else $error("task result outside a running round");

    a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.is_summary && res.task_id_res == '0)
        else $error("last result is not a clean summary");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.op == OP_CLEAR |=> !res_valid && !busy)
        else $error("clear request produced output or busy");

endmodule

bind prerequisite_level_scheduler_core psched_chk u_psched_chk (.*);
